@@ hw/rtl/b64lw_pkg.sv @@
package b64lw_pkg;

    localparam int unsigned CFG_BPL_W     = 6;
    localparam logic [5:0]  BPL_RESET     = 6'd18;
    localparam logic [7:0]  NL_CHAR       = 8'h0A;
    localparam logic [7:0]  PAD_CHAR      = 8'h3D;
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam logic [2:0]  POS_FIRST     = 3'd0;
    localparam logic [2:0]  POS_SECOND    = 3'd1;
    localparam logic [2:0]  POS_THIRD     = 3'd2;
    localparam logic [2:0]  POS_FOURTH    = 3'd3;
    localparam logic [2:0]  POS_NEWLINE   = 3'd4;

    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] n;
        logic       nl;
        logic       last;
    } t_job;

    function automatic logic [7:0] f_b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/base64_encoder_line_wrap_core.sv @@
// Base64 encoder with line wrapping for MIME bodies.
// Raw bytes enter on the slave stream, one byte per transfer; tlast marks
// the final byte of a stream. Encoded characters leave on the master stream,
// one character per transfer; tlast marks the closing newline of a stream.
// Every third byte, or the final byte, yields four characters ('=' padded
// when the group is partial), followed by a newline when the configured
// number of groups per line is reached or the stream ends.
// A completed group is written into the queue and its characters are then
// loaded one by one into the output register. The output side sends one
// character per cycle while the queue holds a group and the receiver is
// ready; the front accepts one byte per cycle while its two-group queue has
// room. The groups per line register is written by APB at addresses 0 to 3
// (paddr[2] clear) and read back at every address. The user must write it
// only while the block is idle; the block itself does not enforce this.
// A value of 0 acts like 1.
// Reset clears the held bytes, group count, queue, output valid flag and
// character position, and sets the register to 18 (72 characters per line).
// When the receiver stalls, the current character is held; the queue then
// fills and s_axis_tready falls until characters are taken again.
module base64_encoder_line_wrap_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [7:0]                       s_axis_tdata,   // data_byte
    input  logic                             s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // out_char
    output logic                             m_axis_tlast,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [b64lw_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);
    import b64lw_pkg::*;

    logic [CFG_BPL_W-1:0] r_bpl;
    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_empty;
    t_job                 w_job_in;
    t_job                 w_job_out;

    assign pready = 1'b1;
    assign prdata = {{(32 - CFG_BPL_W){1'b0}}, r_bpl};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpl <= BPL_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_bpl <= pwdata[CFG_BPL_W-1:0];
        end
    end

    b64lw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .i_full  (w_full),
        .i_bpl   (r_bpl),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    b64lw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    b64lw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_job    (w_job_out),
        .i_tready (m_axis_tready),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

@@ hw/rtl/b64lw_front.sv @@
module b64lw_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    input  logic                 i_final,
    input  logic                 i_full,
    input  logic [5:0]           i_bpl,
    output logic                 o_ready,
    output logic                 o_push,
    output b64lw_pkg::t_job      o_job
);
    import b64lw_pkg::*;

    logic [15:0] r_pend, n_pend;
    logic [1:0]  r_cnt, n_cnt;
    logic [5:0]  r_groups, n_groups;
    logic [1:0]  w_n;
    logic        w_accept;
    logic        w_complete;
    logic [5:0]  w_limit;
    logic [5:0]  w_g1;
    logic        w_wrap;

    assign o_ready    = !i_full;
    assign w_accept   = i_valid && o_ready;
    assign w_n        = r_cnt + 2'd1;
    assign w_complete = i_final || (w_n == 2'd3);
    assign w_limit    = (i_bpl == 6'd0) ? 6'd1 : i_bpl;
    assign w_g1       = r_groups + 6'd1;
    assign w_wrap     = (w_g1 >= w_limit);
    assign o_push     = w_accept && w_complete;

    always_comb begin
        o_job.b0   = (w_n == 2'd1) ? i_byte : r_pend[15:8];
        o_job.b1   = (w_n == 2'd1) ? 8'd0 : ((w_n == 2'd2) ? i_byte : r_pend[7:0]);
        o_job.b2   = (w_n == 2'd3) ? i_byte : 8'd0;
        o_job.n    = w_n;
        o_job.nl   = i_final || w_wrap;
        o_job.last = i_final;
    end

    always_comb begin
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_groups = r_groups;
        if (w_accept) begin
            if (!w_complete) begin
                if (w_n == 2'd1) begin
                    n_pend = {i_byte, 8'd0};
                end else begin
                    n_pend = {r_pend[15:8], i_byte};
                end
                n_cnt = w_n;
            end else begin
                n_pend   = 16'd0;
                n_cnt    = 2'd0;
                n_groups = o_job.nl ? 6'd0 : w_g1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 16'd0;
            r_cnt    <= 2'd0;
            r_groups <= 6'd0;
        end else begin
            r_pend   <= n_pend;
            r_cnt    <= n_cnt;
            r_groups <= n_groups;
        end
    end

endmodule

@@ hw/rtl/b64lw_queue.sv @@
module b64lw_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64lw_pkg::t_job      i_job,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output b64lw_pkg::t_job      o_job
);
    import b64lw_pkg::*;

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_job   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= !r_wptr;
            end
            if (w_pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

@@ hw/rtl/b64lw_back.sv @@
module b64lw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  b64lw_pkg::t_job      i_job,
    input  logic                 i_tready,
    output logic                 o_pop,
    output logic                 o_tvalid,
    output logic [7:0]           o_tdata,
    output logic                 o_tlast
);
    import b64lw_pkg::*;

    logic [2:0] r_pos, n_pos;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       w_load;
    logic [7:0] w_char;
    logic       w_last;
    logic       w_end;

    assign w_load = !i_empty && (!r_valid || i_tready);

    always_comb begin
        w_last = 1'b0;
        unique case (r_pos)
            POS_FIRST:  w_char = f_b64_char(i_job.b0[7:2]);
            POS_SECOND: w_char = f_b64_char({i_job.b0[1:0], i_job.b1[7:4]});
            POS_THIRD:  w_char = (i_job.n > 2'd1) ?
                                 f_b64_char({i_job.b1[3:0], i_job.b2[7:6]}) : PAD_CHAR;
            POS_FOURTH: w_char = (i_job.n > 2'd2) ? f_b64_char(i_job.b2[5:0]) : PAD_CHAR;
            POS_NEWLINE: begin
                w_char = NL_CHAR;
                w_last = i_job.last;
            end
            default:    w_char = NL_CHAR;
        endcase
    end

    assign w_end = (r_pos == POS_NEWLINE) || ((r_pos == POS_FOURTH) && !i_job.nl);
    assign o_pop = w_load && w_end;

    always_comb begin
        n_pos = r_pos;
        if (w_load) begin
            n_pos = w_end ? POS_FIRST : r_pos + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= POS_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (w_load) begin
                r_valid <= 1'b1;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_char;
    assign o_tlast  = r_last;

endmodule

@@ hw/rtl/b64lw_checker.sv @@
module b64lw_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Stalled output transfer changed.");

    a_last_is_nl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == 8'h0A)
        else $error("Final character is not a newline.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Output valid after reset.");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && !paddr[2] |=>
            prdata[5:0] == $past(pwdata[5:0]) && prdata[31:6] == 26'd0)
        else $error("Register read-back does not match the write.");

endmodule

bind base64_encoder_line_wrap_core b64lw_checker u_b64lw_checker (.*);
